// File: hw/rtl/brush_stamp_packed_framebuffer_top_macros.svh
`ifndef BRUSH_STAMP_PACKED_FRAMEBUFFER_TOP_MACROS_SVH
`define BRUSH_STAMP_PACKED_FRAMEBUFFER_TOP_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define BSPF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs across reset.
`define BSPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bspf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bspf_pkg;

  localparam int BSPF_WIDTH_PX    = 128;
  localparam int BSPF_HEIGHT_ROWS = 136;

  localparam int IN_W  = 24;
  localparam int OUT_W = 8;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_STAMP = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] SIZE_4    = 2'd0;
  localparam logic [1:0] SIZE_8    = 2'd1;
  localparam logic [1:0] SIZE_12   = 2'd2;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  localparam logic [1:0] SHAPE_SQUARE = 2'd0;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [1:0] SHAPE_SLASH  = 2'd2;

  // Stamp window: 13 rows by 4 byte columns.
  localparam logic [3:0] DY_LAST = 4'd12;
  localparam logic [1:0] BC_LAST = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic stp_step;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } bspf_cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       clr_last;
    logic       stp_last;
  } bspf_stat_t;

  // True when brush offset (dx, dy) from the box corner is painted.
  function automatic logic brush_hit(input logic [1:0] shape, input logic [1:0] sc,
                                     input logic [3:0] dx, input logic [3:0] dy);
    logic [4:0] s;
    logic [4:0] sum;
    logic [3:0] k;
    logic       hit;
    s   = 5'd4 + {1'b0, sc, 2'b00};
    sum = {1'b0, dx} + {1'b0, dy};
    k   = (dy <= 4'd3) ? dy : (4'd12 - dy);
    hit = 1'b0;
    if (sc != SIZE_NONE) begin
      case (shape)
        SHAPE_SQUARE: hit = ({1'b0, dx} < s) && ({1'b0, dy} < s);
        SHAPE_CIRCLE: begin
          case (sc)
            SIZE_4: begin
              if (dy inside {[4'd1:4'd3]}) hit = (dx <= 4'd4);
              else if (dy inside {4'd0, 4'd4}) hit = (dx inside {[4'd1:4'd3]});
            end
            SIZE_8: begin
              if (dy inside {[4'd3:4'd5]}) hit = (dx <= 4'd8);
              else if (dy inside {4'd1, 4'd2, 4'd6, 4'd7}) hit = (dx inside {[4'd1:4'd7]});
              else if (dy inside {4'd0, 4'd8}) hit = (dx inside {[4'd3:4'd5]});
            end
            SIZE_12: begin
              if (dy inside {[4'd4:4'd8]}) hit = (dx <= 4'd12);
              else if (dy <= 4'd12) hit = (dx >= (4'd4 - k)) && (dx <= (4'd8 + k));
            end
            default: hit = 1'b0;
          endcase
        end
        SHAPE_SLASH: hit = (sum == s - 5'd1) || (sum == s - 5'd2) ||
                           ((sum == s) && (dx != 4'd0) && (dy != 4'd0));
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bspf_store.sv
`timescale 1ns / 1ps
`default_nettype none
module bspf_store #(
  parameter int DEPTH  = 4352,
  parameter int ADDR_W = 13
) (
  input  wire              clk,
  input  wire              we,
  input  wire [ADDR_W-1:0] waddr,
  input  wire [7:0]        wdata,
  input  wire              re,
  input  wire [ADDR_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bspf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bspf_ctrl
  import bspf_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  input  wire             s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire             m_tready,
  input  wire bspf_stat_t stat,
  output bspf_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_CLEAR, ST_STAMP, ST_DRAIN, ST_RD_ISSUE, ST_RD_WAIT, ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && s_tvalid;
    cmd.clr_step   = (state == ST_SWEEP) || (state == ST_CLEAR);
    cmd.stp_step   = (state == ST_STAMP);
    cmd.rd_issue   = (state == ST_RD_ISSUE);
    cmd.rd_capture = (state == ST_RD_WAIT);
    cmd.out_load   = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SWEEP;
      m_tvalid <= 1'b0;
    end else begin
      // raise on a fresh result, hold until the beat is taken
      m_tvalid <= cmd.out_load || (m_tvalid && !m_tready);
      case (state)
        ST_SWEEP: begin
          if (stat.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            case (stat.in_mode)
              MODE_CLEAR: state <= ST_CLEAR;
              MODE_STAMP: state <= ST_STAMP;
              MODE_READ:  state <= ST_RD_ISSUE;
              default:    state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          if (stat.clr_last) state <= ST_DONE;
        end
        ST_STAMP: begin
          if (stat.stp_last) state <= ST_DRAIN;
        end
        ST_DRAIN:    state <= ST_DONE;
        ST_RD_ISSUE: state <= ST_RD_WAIT;
        ST_RD_WAIT:  state <= ST_DONE;
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bspf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bspf_datapath
  import bspf_pkg::*;
#(
  parameter int WIDTH_PX    = BSPF_WIDTH_PX,
  parameter int HEIGHT_ROWS = BSPF_HEIGHT_ROWS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire [IN_W-1:0]   s_tdata,
  output logic [OUT_W-1:0] m_tdata,
  input  wire bspf_cmd_t   cmd,
  output bspf_stat_t       stat
);

  localparam int BYTE_COLS   = (WIDTH_PX + 3) / 4;
  localparam int STORE_BYTES = BYTE_COLS * HEIGHT_ROWS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LIN_W       = $clog2((BYTE_COLS + 40) * (HEIGHT_ROWS + 300));
  localparam int COL_W       = $clog2(WIDTH_PX + 256);
  localparam int ROW_W       = $clog2(HEIGHT_ROWS + 300);

  // Held item fields
  logic [6:0] pos_x;
  logic [7:0] pos_y;
  logic [1:0] size_code;
  logic [1:0] brush_shape;
  logic [1:0] colour;

  // Walk state
  logic [ADDR_W-1:0] clr_cnt;
  logic [LIN_W-1:0]  cur_base;
  logic [1:0]        bcol;
  logic [3:0]        dy;

  // Pending write of the stamp pipeline
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_sel;

  logic [1:0] work_code;
  logic       work_clip;
  logic [1:0] pixel_code;
  logic       clipped;

  logic [LIN_W-1:0] lin;
  logic [ROW_W-1:0] row;
  logic             row_in;
  logic [3:0]       mask;
  logic             clip_hit;
  logic [7:0]       sel;
  logic             rd_out;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [7:0]       mem_rdata;
  logic [7:0]       fill;

  assign lin    = cur_base + LIN_W'(pos_y) + LIN_W'(dy);
  assign row    = ROW_W'(pos_y) + ROW_W'(dy);
  assign row_in = row < ROW_W'(HEIGHT_ROWS);
  assign rd_out = (COL_W'(pos_x) >= COL_W'(WIDTH_PX)) || (ROW_W'(pos_y) >= ROW_W'(HEIGHT_ROWS));
  assign fill   = {4{colour}};

  // Pixel mask of the current byte of the stamp window
  always_comb begin
    logic [3:0]       off;
    logic [3:0]       dx;
    logic [COL_W-1:0] col;
    logic             hit;
    mask     = '0;
    clip_hit = 1'b0;
    sel      = '0;
    for (int j = 0; j < 4; j++) begin
      off = {bcol, 2'(j)};
      dx  = off - {2'b00, pos_x[1:0]};
      col = COL_W'({pos_x[6:2], 2'b00}) + COL_W'(off);
      hit = (off >= {2'b00, pos_x[1:0]}) && brush_hit(brush_shape, size_code, dx, dy);
      mask[j] = hit && row_in && (col < COL_W'(WIDTH_PX));
      if (hit && !mask[j]) clip_hit = 1'b1;
      sel[7 - 2*j -: 2] = {2{mask[j]}};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = (mem_rdata & ~pend_sel) | (fill & pend_sel);
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (pend_valid) begin
      mem_we = 1'b1;
    end
    mem_re = (cmd.stp_step && (mask != 4'd0)) || (cmd.rd_issue && !rd_out);
  end

  bspf_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (lin[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  assign stat.in_mode  = s_tdata[1:0];
  assign stat.clr_last = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
  assign stat.stp_last = (bcol == BC_LAST) && (dy == DY_LAST);
  assign m_tdata       = {5'b00000, clipped, pixel_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.stp_step && (mask != 4'd0);
      if (cmd.load) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step && !stat.clr_last) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x       <= s_tdata[8:2];
      pos_y       <= s_tdata[16:9];
      size_code   <= s_tdata[18:17];
      brush_shape <= s_tdata[20:19];
      colour      <= s_tdata[22:21];
      cur_base    <= LIN_W'(s_tdata[8:4]) * LIN_W'(HEIGHT_ROWS);
      bcol        <= '0;
      dy          <= '0;
      work_code   <= '0;
      work_clip   <= 1'b0;
    end else begin
      if (cmd.stp_step) begin
        // advance down the rows, then to the next byte column
        if (dy == DY_LAST) begin
          dy       <= '0;
          bcol     <= bcol + 1'b1;
          cur_base <= cur_base + LIN_W'(HEIGHT_ROWS);
        end else begin
          dy <= dy + 1'b1;
        end
        if (clip_hit) work_clip <= 1'b1;
      end
      if (cmd.rd_issue && rd_out) begin
        work_clip <= 1'b1;
      end
      if (cmd.rd_capture && !work_clip) begin
        case (pos_x[1:0])
          2'd0:    work_code <= mem_rdata[7:6];
          2'd1:    work_code <= mem_rdata[5:4];
          2'd2:    work_code <= mem_rdata[3:2];
          default: work_code <= mem_rdata[1:0];
        endcase
      end
    end
    pend_addr <= lin[ADDR_W-1:0];
    pend_sel  <= sel;
    if (cmd.out_load) begin
      pixel_code <= work_code;
      clipped    <= work_clip;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/brush_stamp_packed_framebuffer_top.sv
// Brush stamp framebuffer: 2-bit pixels packed four to a byte, leftmost pixel in the
// top bit pair. Input beats arrive on s_tvalid/s_tready/s_tdata; each yields exactly
// one result beat on m_tvalid/m_tready/m_tdata.
// Items are handled one at a time; s_tready is high only while the block is idle.
// Steps per item, from accept to result valid:
//   read  - address the byte, capture the selected pixel, load the output
//   stamp - the 13-row by 4-byte window is walked one byte per cycle,
//           the read of one byte overlapping the masked write of the previous one;
//           then the last byte is written and the output is loaded
//   clear - every stored byte is written with zero, then the output is loaded
//   other - the output is loaded directly
// The next item can be taken in the same cycle that the result turns valid.
// The byte store has one write and one read port; its throughput sets this pace.
// Reset: a clearing pass writes every byte to zero, with s_tready low throughout.
// The result sits in an output register: when the receiver stalls, the beat holds
// and the next item is accepted but its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module brush_stamp_packed_framebuffer_top
  import bspf_pkg::*;
#(
  parameter int WIDTH_PX    = BSPF_WIDTH_PX,
  parameter int HEIGHT_ROWS = BSPF_HEIGHT_ROWS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire [IN_W-1:0]   s_tdata,   // mode[1:0], pos_x[8:2], pos_y[16:9], size_code[18:17],
                                      // brush_shape[20:19], colour[22:21], zero[23]
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [OUT_W-1:0] m_tdata    // pixel_code[1:0], clipped[2], zero[7:3]
);

  bspf_cmd_t  cmd;
  bspf_stat_t stat;

  bspf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bspf_datapath #(
    .WIDTH_PX    (WIDTH_PX),
    .HEIGHT_ROWS (HEIGHT_ROWS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bspf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "brush_stamp_packed_framebuffer_top_macros.svh"
module bspf_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata
);

  `BSPF_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result beat changed while stalled")
  `BSPF_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[7:3] == 5'd0), "result padding not zero")
  `BSPF_ASSERT_ALWAYS(a_sweep_after_rst, clk, rst |=> !s_tready, "input ready during clearing pass")
  `BSPF_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")
  `BSPF_ASSERT(a_clip_no_code, clk, rst, (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == 2'd0), "clipped result carries a pixel code")

endmodule

bind brush_stamp_packed_framebuffer_top bspf_checker u_bspf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
